>>> src/ter_pkg.sv
package ter_pkg;

  // field widths
  localparam int CAP_W  = 32;
  localparam int SYS_W  = 63;
  localparam int TIME_W = 64;
  localparam int PER_W  = 32;
  localparam int CNT_W  = 6;

  // last step index of each iterative pass
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(TIME_W - 1);
  localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(PER_W - 1);

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV1,
    S_ADJ,
    S_MUL,
    S_SUM,
    S_LIM,
    S_CMP,
    S_DIV2,
    S_FIX,
    S_DONE
  } state_t;

  // step unit operations
  typedef enum logic {
    OP_DIV,
    OP_MUL
  } op_t;

  // one step request: x holds remainder or accumulator, y dividend/quotient or multiplicand
  typedef struct packed {
    op_t               op;
    logic              mbit;
    logic [PER_W-1:0]  per;
    logic [TIME_W-1:0] x;
    logic [TIME_W-1:0] y;
  } step_req_t;

  typedef struct packed {
    logic [TIME_W-1:0] x;
    logic [TIME_W-1:0] y;
  } step_rsp_t;

endpackage

>>> src/timestamp_epoch_reconstruct.sv
// Order: a zero period or an out-of-range channel takes the input straight to the result state;
//   otherwise divide, adjust, multiply, sum, limit, compare and, if needed, the history correction.
// Throughput: one item at a time, the next input transfer after the result enters the output
//   register; the shared step unit runs a 64-step divide, a 32-step multiply and a 64-step divide.
// Reset (rst, synchronous, active high) clears the period, the per-channel history and
//   the handshake state.
module timestamp_epoch_reconstruct #(
  parameter int CHANNELS = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [ter_pkg::PER_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ter_pkg::CAP_W-1:0]     capture_time,
  input  logic [ter_pkg::SYS_W-1:0]     system_time,
  input  logic                          channel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ter_pkg::TIME_W-1:0]    full_time
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  ter_pkg::state_t            state;
  ter_pkg::state_t            state_next;
  logic [ter_pkg::CNT_W-1:0]  cnt;
  logic [ter_pkg::PER_W-1:0]  period_reg;
  logic [ter_pkg::CAP_W-1:0]  cap;
  logic [ter_pkg::SYS_W-1:0]  sys;
  logic [CH_W-1:0]            ch_idx;
  logic                       upd;
  logic                       cond;
  logic [ter_pkg::TIME_W-1:0] last_q;
  logic [ter_pkg::TIME_W-1:0] ux;
  logic [ter_pkg::TIME_W-1:0] uy;
  logic [ter_pkg::TIME_W-1:0] r;
  logic [ter_pkg::TIME_W-1:0] lim;
  logic [ter_pkg::TIME_W-1:0] last_result [CHANNELS];

  ter_pkg::step_req_t         step_req;
  ter_pkg::step_rsp_t         step_rsp;

  logic                       in_xfer;
  logic                       out_free;
  logic                       in_range;
  logic [CH_W-1:0]            in_idx;
  logic [ter_pkg::PER_W-2:0]  half;
  logic [ter_pkg::CAP_W-1:0]  pos;
  logic                       ahead;
  logic                       behind;
  logic [ter_pkg::TIME_W-1:0] sys64;

  assign in_ready = (state == ter_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign in_range = (CHANNELS > 1) || (channel == 1'b0);
  assign in_idx   = CH_W'(channel);
  assign half     = period_reg[ter_pkg::PER_W-1:1];
  assign pos      = ux[ter_pkg::CAP_W-1:0];
  assign sys64    = {1'b0, sys};

  // epoch direction from capture against position
  assign ahead  = (cap > pos) && ((cap - pos) > {1'b0, half});
  assign behind = (pos > cap) && ((pos - cap) > {1'b0, half});

  // shared step unit
  assign step_req.op   = (state == ter_pkg::S_MUL) ? ter_pkg::OP_MUL : ter_pkg::OP_DIV;
  assign step_req.mbit = period_reg[5'(ter_pkg::MUL_LAST) - cnt[4:0]];
  assign step_req.per  = period_reg;
  assign step_req.x    = ux;
  assign step_req.y    = uy;

  ter_step_unit u_step (
    .req (step_req),
    .rsp (step_rsp)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ter_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      ter_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (period_reg == '0 || !in_range) begin
            state_next = ter_pkg::S_DONE;
          end else begin
            state_next = ter_pkg::S_DIV1;
          end
        end
      end
      ter_pkg::S_DIV1: begin
        if (cnt == ter_pkg::DIV_LAST) state_next = ter_pkg::S_ADJ;
      end
      ter_pkg::S_ADJ:  state_next = ter_pkg::S_MUL;
      ter_pkg::S_MUL: begin
        if (cnt == ter_pkg::MUL_LAST) state_next = ter_pkg::S_SUM;
      end
      ter_pkg::S_SUM:  state_next = ter_pkg::S_LIM;
      ter_pkg::S_LIM:  state_next = ter_pkg::S_CMP;
      ter_pkg::S_CMP: begin
        if (cond && (last_q > lim)) begin
          state_next = ter_pkg::S_DIV2;
        end else begin
          state_next = ter_pkg::S_DONE;
        end
      end
      ter_pkg::S_DIV2: begin
        if (cnt == ter_pkg::DIV_LAST) state_next = ter_pkg::S_FIX;
      end
      ter_pkg::S_FIX:  state_next = ter_pkg::S_DONE;
      ter_pkg::S_DONE: begin
        if (out_free) state_next = ter_pkg::S_IDLE;
      end
      default: state_next = ter_pkg::S_IDLE;
    endcase
  end

  // period register and per-channel history
  always_ff @(posedge clk) begin
    if (rst) begin
      period_reg <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        last_result[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) period_reg <= cfg_wr_data;
      if (state == ter_pkg::S_DONE && out_free && upd) last_result[ch_idx] <= r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ter_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ter_pkg::S_DONE && out_free) full_time <= r;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upd <= 1'b0;
      cnt <= '0;
    end else begin
      case (state)
        ter_pkg::S_IDLE: begin
          if (in_xfer) begin
            cap    <= capture_time;
            sys    <= system_time;
            ch_idx <= in_idx;
            last_q <= in_range ? last_result[in_idx] : '0;
            r      <= ter_pkg::TIME_W'(capture_time);
            upd    <= (period_reg != '0) && in_range;
            ux     <= '0;
            uy     <= ter_pkg::TIME_W'(system_time);
            cnt    <= '0;
          end
        end
        ter_pkg::S_DIV1, ter_pkg::S_MUL, ter_pkg::S_DIV2: begin
          ux  <= step_rsp.x;
          uy  <= step_rsp.y;
          cnt <= cnt + 1'b1;
        end
        ter_pkg::S_ADJ: begin
          // uy holds the epoch, ux the position
          if (ahead) begin
            uy <= uy - 1'b1;
          end else if (behind) begin
            uy <= uy + 1'b1;
          end
          ux  <= '0;
          cnt <= '0;
        end
        ter_pkg::S_SUM: begin
          r    <= ux + ter_pkg::TIME_W'(cap);
          cond <= (last_q != '0) && (last_q <= sys64) &&
                  ((sys64 - last_q) <= {31'b0, period_reg, 1'b0});
        end
        ter_pkg::S_LIM: begin
          lim <= r + ter_pkg::TIME_W'(half);
        end
        ter_pkg::S_CMP: begin
          // r + (last - lim) is last - half; the round-up is added after the divide
          if (cond && (last_q > lim)) begin
            r   <= last_q - ter_pkg::TIME_W'(half);
            ux  <= '0;
            uy  <= last_q - lim;
            cnt <= '0;
          end
        end
        ter_pkg::S_FIX: begin
          if (ux[ter_pkg::PER_W-1:0] != '0) begin
            r <= r + ter_pkg::TIME_W'(period_reg - ux[ter_pkg::PER_W-1:0]);
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // disabled reconstruction goes straight to the result with the capture
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && period_reg == '0) |=>
      (state == ter_pkg::S_DONE && r == ter_pkg::TIME_W'($past(capture_time)) && !upd))
    else $error("bypass path did not pass the capture through");

  // a transfer makes the block busy on the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready)
    else $error("input taken while an item is in work");

  // multiply pass never runs past the period width
  a_mul_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ter_pkg::S_MUL) |-> (cnt <= ter_pkg::MUL_LAST))
    else $error("multiply step count overrun");

  // a finished item lands in the output register and frees the input
  a_done: assert property (@(posedge clk) disable iff (rst)
    (state == ter_pkg::S_DONE && out_free) |=> (out_valid && in_ready))
    else $error("finished item not delivered to the output register");

  // the divider remainder stays below the period
  a_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ter_pkg::S_FIX || state == ter_pkg::S_ADJ) |->
      (ux < ter_pkg::TIME_W'(period_reg)))
    else $error("divider remainder not below period");
`endif

endmodule

>>> src/ter_step_unit.sv
module ter_step_unit (
  input  ter_pkg::step_req_t req,
  output ter_pkg::step_rsp_t rsp
);

  logic [ter_pkg::PER_W:0]    rem_sh;
  logic [ter_pkg::TIME_W-1:0] a;
  logic [ter_pkg::TIME_W-1:0] b;
  logic                       cin;
  logic [ter_pkg::TIME_W:0]   sum;
  logic                       ge;

  // one shared 64-bit adder: restoring divide step or shift-add multiply step
  always_comb begin
    rem_sh = {req.x[ter_pkg::PER_W-1:0], req.y[ter_pkg::TIME_W-1]};
    a      = '0;
    b      = '0;
    cin    = 1'b0;
    unique case (req.op)
      ter_pkg::OP_DIV: begin
        a   = ter_pkg::TIME_W'(rem_sh);
        b   = ~ter_pkg::TIME_W'(req.per);
        cin = 1'b1;
      end
      ter_pkg::OP_MUL: begin
        a   = {req.x[ter_pkg::TIME_W-2:0], 1'b0};
        b   = req.mbit ? req.y : '0;
        cin = 1'b0;
      end
      default: begin
        a   = '0;
        b   = '0;
        cin = 1'b0;
      end
    endcase
    sum = {1'b0, a} + {1'b0, b} + (ter_pkg::TIME_W + 1)'(cin);
    // carry out of a + ~per + 1 means the shifted remainder is not below the period
    ge  = sum[ter_pkg::TIME_W];
    unique case (req.op)
      ter_pkg::OP_DIV: begin
        rsp.x = ge ? sum[ter_pkg::TIME_W-1:0] : a;
        rsp.y = {req.y[ter_pkg::TIME_W-2:0], ge};
      end
      ter_pkg::OP_MUL: begin
        rsp.x = sum[ter_pkg::TIME_W-1:0];
        rsp.y = req.y;
      end
      default: begin
        rsp.x = req.x;
        rsp.y = req.y;
      end
    endcase
  end

endmodule

>>> tb/tb_timestamp_epoch_reconstruct.sv
module tb_timestamp_epoch_reconstruct;

  localparam int CAP_W  = ter_pkg::CAP_W;
  localparam int SYS_W  = ter_pkg::SYS_W;
  localparam int TIME_W = ter_pkg::TIME_W;
  localparam int PER_W  = ter_pkg::PER_W;

  localparam logic [PER_W-1:0] PER_MAX = {PER_W{1'b1}};
  localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};
  localparam logic [SYS_W-1:0] SYS_MAX = {SYS_W{1'b1}};

  // one capture event offered to the block
  typedef struct {
    logic [CAP_W-1:0] cap;
    logic [SYS_W-1:0] sys;
    logic             ch;
  } capture_evt_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [PER_W-1:0]     cfg_wr_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CAP_W-1:0]     capture_time = '0;
  logic [SYS_W-1:0]     system_time = '0;
  logic                 channel = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [TIME_W-1:0]    full_time;

  // predictor state: period as written, last arrival time per channel
  logic [PER_W-1:0]     period_now = '0;
  logic [TIME_W-1:0]    arrival_hist [2] = '{default: '0};

  capture_evt_t         capture_pending_q [$];
  logic [TIME_W-1:0]    arrival_expect_q [$];
  capture_evt_t         drv_evt;
  logic [TIME_W-1:0]    mon_expected;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;

  timestamp_epoch_reconstruct #(.CHANNELS(2)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .capture_time (capture_time),
    .system_time  (system_time),
    .channel      (channel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .full_time    (full_time)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit, several times the slowest legal run
  initial begin
    #32_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // expected arrival time for one capture, updates the channel history
  function automatic logic [TIME_W-1:0] predict_arrival(input logic [CAP_W-1:0] cap,
                                                        input logic [SYS_W-1:0] sys,
                                                        input logic ch);
    logic [63:0]        per, half, pos, epoch, r, lim, d, q, sys64, cap64, last;
    logic signed [63:0] skew;
    if (period_now == '0) begin
      return {32'b0, cap};
    end
    per   = {32'b0, period_now};
    half  = per >> 1;
    sys64 = {1'b0, sys};
    cap64 = {32'b0, cap};
    pos   = sys64 % per;
    epoch = sys64 / per;
    // both sides are below 2^32, so the signed difference is exact
    skew  = $signed(cap64) - $signed(pos);
    if (skew > $signed(half)) begin
      epoch = epoch - 64'd1;
    end else if (skew < -$signed(half)) begin
      epoch = epoch + 64'd1;
    end
    r = epoch * per + cap64;
    // pull forward against a recent history value
    last = arrival_hist[ch];
    if (last != 64'd0 && last <= sys64 && (sys64 - last) <= 64'd2 * per) begin
      lim = r + half;
      if (last > lim) begin
        d = last - lim;
        q = d / per + ((d % per != 64'd0) ? 64'd1 : 64'd0);
        r = r + q * per;
      end
    end
    arrival_hist[ch] = r;
    return r;
  endfunction

  // driver: offers pending captures, predicts on each input transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        arrival_expect_q.push_back(predict_arrival(capture_time, system_time, channel));
      end
      if (!in_valid || in_ready) begin
        if (capture_pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          drv_evt = capture_pending_q.pop_front();
          in_valid     <= 1'b1;
          capture_time <= drv_evt.cap;
          system_time  <= drv_evt.sys;
          channel      <= drv_evt.ch;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each output transfer against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (arrival_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected full_time %h", full_time));
        end else begin
          mon_expected = arrival_expect_q.pop_front();
          if (full_time !== mon_expected) begin
            report_mismatch($sformatf("full_time %h, expected %h", full_time, mon_expected));
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic queue_capture(input logic [CAP_W-1:0] cap, input logic [SYS_W-1:0] sys,
                               input logic ch);
    capture_evt_t e;
    e.cap = cap;
    e.sys = sys;
    e.ch  = ch;
    capture_pending_q.push_back(e);
  endtask

  // sender holds off until the block has returned everything
  task automatic wait_drained();
    do @(negedge clk);
    while (capture_pending_q.size() != 0 || in_valid || arrival_expect_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_period(input logic [PER_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    period_now  = v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // mostly a system clock moving forward with captures near it, plus noise
  task automatic queue_random(input int n, input bit from_zero);
    logic [63:0]      per, sys_now, advance, span, phase_off;
    logic [CAP_W-1:0] cap;
    logic [SYS_W-1:0] sys;
    logic             ch;
    int               roll;
    per     = {32'b0, period_now};
    sys_now = from_zero ? 64'd0 : {2'b00, $urandom, 30'($urandom)};
    repeat (n) begin
      roll = $urandom_range(99);
      ch   = 1'($urandom_range(1));
      if (roll < 80) begin
        if (roll < 70) begin
          // clock moves forward, mostly within a period
          span    = (per == 0) ? 64'd1000 : ((roll < 60) ? per : 64'd3 * per);
          advance = rand64() % (span + 64'd1);
          sys_now = sys_now + advance;
        end else begin
          // clock read behind the channel history
          span    = (per == 0) ? 64'd1000 : per;
          advance = rand64() % (span + 64'd1);
          sys_now = (advance > sys_now) ? 64'd0 : sys_now - advance;
        end
        phase_off = (per == 0) ? 64'd0 : rand64() % per;
        cap = (per == 0) ? $urandom : CAP_W'((sys_now + phase_off) % per);
        sys = sys_now[SYS_W-1:0];
      end else if (roll < 90) begin
        // capture at or just above the period, modulo 2^32
        cap = period_now + CAP_W'($urandom_range(1000));
        sys = sys_now[SYS_W-1:0];
      end else begin
        cap = $urandom;
        sys = SYS_W'(rand64());
      end
      queue_capture(cap, sys, ch);
    end
  endtask

  task automatic run_phase(input logic [PER_W-1:0] per, input int n, input int idle_pct,
                           input int stall_pct, input bit from_zero);
    wait_drained();
    write_period(per);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    queue_random(n, from_zero);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // pass-through with the period cleared
    write_period('0);
    queue_capture('0, '0, 1'b0);
    queue_capture(CAP_MAX, SYS_MAX, 1'b1);
    queue_capture(32'h1234_5678, 63'h2AAA_5555_AAAA_5555, 1'b0);

    // even period: each epoch adjustment, history, wide capture, epoch wrap
    wait_drained();
    write_period(32'd1000);
    queue_capture(32'd0, 63'd5000, 1'b0);
    queue_capture(32'd600, 63'd5000, 1'b0);
    queue_capture(32'd900, 63'd5900, 1'b0);
    queue_capture(32'd100, 63'd5950, 1'b1);
    queue_capture(32'd50, 63'd7000, 1'b1);
    queue_capture(32'd10, 63'd6500, 1'b1);
    queue_capture(32'd5000, 63'd6000, 1'b0);
    queue_capture(32'd900, 63'd300, 1'b0);

    // largest period, odd
    wait_drained();
    write_period(PER_MAX);
    queue_capture(CAP_MAX, SYS_MAX, 1'b0);
    queue_capture('0, SYS_MAX, 1'b1);
    queue_capture(CAP_MAX, '0, 1'b0);
    queue_capture(32'h7FFF_FFFF, 63'h1_0000_0000, 1'b1);

    // smallest periods
    wait_drained();
    write_period(32'd1);
    queue_capture(32'd0, 63'd12345, 1'b0);
    queue_capture(32'd1, 63'd12346, 1'b0);
    queue_capture(CAP_MAX, 63'd99, 1'b1);
    wait_drained();
    write_period(32'd2);
    queue_capture(32'd1, 63'd7, 1'b0);
    queue_capture(32'd0, 63'd8, 1'b1);

    // random phases over periods and flow-control patterns
    run_phase(PER_W'($urandom_range(3, 5000)), 300, 0, 0, 1'b0);
    run_phase(PER_MAX, 250, 73, 0, 1'b0);
    run_phase($urandom, 300, 0, 73, 1'b0);
    run_phase(32'd1, 150, 26, 26, 1'b0);
    run_phase('0, 100, 0, 0, 1'b0);
    run_phase(PER_W'($urandom_range(3, 65535)), 300, 26, 26, 1'b0);
    run_phase(32'd2, 150, 73, 0, 1'b0);
    run_phase($urandom | 32'h8000_0000, 300, 0, 73, 1'b1);
    run_phase(PER_W'($urandom_range(3, 5000)), 150, 0, 0, 1'b0);

    wait_drained();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
